// File: sv/vlan_learning_switch_forwarder_assert.svh
// Assertion macros shared by the checker of the VLAN learning switch forwarder.
// Plain text header with no dependencies; include by bare file name.
`ifndef VLAN_LEARNING_SWITCH_FORWARDER_ASSERT_SVH
`define VLAN_LEARNING_SWITCH_FORWARDER_ASSERT_SVH

// Clocked check that is switched off while reset is asserted.
`define VLSF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds across reset.
`define VLSF_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: sv/vlsf_pkg.sv
// Shared constants, codes and controller/datapath interface types of the forwarder.
// No dependencies; imported by every module of the block.
`default_nettype none
package vlsf_pkg;
    localparam int NUM_PORTS   = 4;
    localparam int PORT_W      = 2;
    localparam int TABLE_DEPTH = 512;
    localparam int TBL_IDX_W   = $clog2(TABLE_DEPTH);
    localparam int TBL_CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int VLAN_SLOTS  = 4096;
    localparam int VID_W       = 12;
    localparam int MAC_W       = 48;
    localparam int IN_DATA_W   = 120;
    localparam int OUT_DATA_W  = 16;

    localparam logic [VID_W-1:0] VID_MAX = 12'd4092;

    localparam logic [1:0] CMD_FRAME      = 2'd0;
    localparam logic [1:0] CMD_SET_TAGGED = 2'd1;
    localparam logic [1:0] CMD_SET_UNTAG  = 2'd2;

    localparam logic [1:0] ACT_FWD    = 2'd0;
    localparam logic [1:0] ACT_STRIP  = 2'd1;
    localparam logic [1:0] ACT_INSERT = 2'd2;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic setup_wr;
        logic vlan_rd;
        logic scan_start;
        logic scan_step;
        logic learn;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       port_ok;
        logic       admit;
        logic       clr_done;
        logic       scan_done;
        logic       pend_any;
        logic       out_free;
    } t_dp_status;
endpackage
`default_nettype wire

// File: sv/vlsf_ctrl.sv
// Sequencing state machine of the forwarder: clear pass, decode, admission,
// table scan, learning and decision emission. Depends on vlsf_pkg.
`default_nettype none
module vlsf_ctrl
    import vlsf_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_s_tvalid,
    output logic       o_s_tready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);
    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_ADM   = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_LEARN = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                if (i_status.cmd inside {CMD_SET_TAGGED, CMD_SET_UNTAG}) begin
                    o_cmd.setup_wr = 1'b1;
                    n_state        = S_IDLE;
                end else if (i_status.cmd == CMD_FRAME && i_status.port_ok) begin
                    o_cmd.vlan_rd = 1'b1;
                    n_state       = S_ADM;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ADM: begin
                if (i_status.admit) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_done) n_state = S_LEARN;
            end
            S_LEARN: begin
                o_cmd.learn = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (!i_status.pend_any) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// File: sv/vlsf_dp.sv
// Datapath of the forwarder: item register, VLAN membership memory, untagged
// VLAN registers, MAC table with scan pipeline, and the output word register.
// Depends on vlsf_pkg.
`default_nettype none
module vlsf_dp
    import vlsf_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  wire [IN_DATA_W-1:0]   i_s_tdata,
    input  wire [1:0]             i_s_tuser,
    output logic                  o_m_tvalid,
    input  wire                   i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tlast
);
    // Item register.
    logic [1:0]        r_cmd;
    logic [PORT_W-1:0] r_ing;
    logic [MAC_W-1:0]  r_src;
    logic [MAC_W-1:0]  r_dst;
    logic              r_tagged;
    logic [VID_W-1:0]  r_vid;
    logic [3:0]        r_mask;
    logic              r_uen;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd    <= i_s_tuser;
            r_ing    <= i_s_tdata[1:0];
            r_src    <= i_s_tdata[49:2];
            r_dst    <= i_s_tdata[97:50];
            r_tagged <= i_s_tdata[98];
            r_vid    <= i_s_tdata[110:99];
            r_mask   <= i_s_tdata[114:111];
            r_uen    <= i_s_tdata[115];
        end
    end

    logic port_ok;
    logic vid_ok;
    assign port_ok = (32'(r_ing) < NUM_PORTS);
    assign vid_ok  = (r_vid <= VID_MAX);

    // Per-port untagged VLAN: bit 12 enable, bits 11..0 VID.
    logic [VID_W:0] r_untag [NUM_PORTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PORTS; p++) r_untag[p] <= {1'b1, {VID_W{1'b0}}};
        end else if (i_cmd.setup_wr && r_cmd == CMD_SET_UNTAG && vid_ok && port_ok) begin
            r_untag[r_ing] <= r_uen ? {1'b1, r_vid} : '0;
        end
    end

    // VLAN of the frame: its own tag or the ingress port's untagged VLAN.
    logic [VID_W-1:0] frame_v;
    assign frame_v = r_tagged ? r_vid : r_untag[r_ing][VID_W-1:0];

    // Tagged membership memory, cleared by a sweep after reset.
    logic [NUM_PORTS-1:0] vlan_mem [VLAN_SLOTS];
    logic [NUM_PORTS-1:0] r_members;
    logic [VID_W-1:0]     r_v;
    logic [VID_W-1:0]     r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            vlan_mem[r_clr_addr] <= '0;
        end else if (i_cmd.setup_wr && r_cmd == CMD_SET_TAGGED && vid_ok) begin
            vlan_mem[r_vid] <= r_mask[NUM_PORTS-1:0];
        end
        if (i_cmd.vlan_rd) begin
            r_members <= vlan_mem[frame_v];
            r_v       <= frame_v;
        end
    end

    // MAC table and its scan pipeline.
    logic [MAC_W-1:0]     tbl_mac  [TABLE_DEPTH];
    logic [PORT_W-1:0]    tbl_port [TABLE_DEPTH];
    logic [TBL_CNT_W-1:0] r_count;
    logic [TBL_CNT_W-1:0] r_ptr;
    logic                 r_rd_vld;
    logic [TBL_IDX_W-1:0] r_rd_idx;
    logic [MAC_W-1:0]     r_rd_mac;
    logic [PORT_W-1:0]    r_rd_port;
    logic                 r_src_hit;
    logic [TBL_IDX_W-1:0] r_src_idx;
    logic                 r_dst_hit;
    logic [PORT_W-1:0]    r_dst_port;
    logic                 tbl_full;

    assign tbl_full = (r_count == TBL_CNT_W'(TABLE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_rd_vld <= (r_ptr < r_count);
            if (r_ptr < r_count) r_ptr <= r_ptr + 1'b1;
        end else if (i_cmd.learn && !r_src_hit && !tbl_full) begin
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) begin
            r_rd_mac  <= tbl_mac[r_ptr[TBL_IDX_W-1:0]];
            r_rd_port <= tbl_port[r_ptr[TBL_IDX_W-1:0]];
            r_rd_idx  <= r_ptr[TBL_IDX_W-1:0];
        end
        if (i_cmd.learn) begin
            if (r_src_hit) begin
                tbl_port[r_src_idx] <= r_ing;
            end else if (!tbl_full) begin
                tbl_mac[r_count[TBL_IDX_W-1:0]]  <= r_src;
                tbl_port[r_count[TBL_IDX_W-1:0]] <= r_ing;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_src_hit <= 1'b0;
            r_dst_hit <= 1'b0;
        end else if (r_rd_vld) begin
            if (r_rd_mac == r_src) begin
                r_src_hit <= 1'b1;
                r_src_idx <= r_rd_idx;
            end
            if (r_rd_mac == r_dst && !r_dst_hit) begin
                r_dst_hit  <= 1'b1;
                r_dst_port <= r_rd_port;
            end
        end
    end

    // Egress rule per port and the set of ports still to report.
    logic [NUM_PORTS-1:0] untag_match;
    logic [NUM_PORTS-1:0] qual;
    logic [NUM_PORTS-1:0] ing_oh;
    logic [NUM_PORTS-1:0] dst_oh;
    logic [NUM_PORTS-1:0] pend_init;
    logic                 dst_self;

    always_comb begin
        ing_oh         = '0;
        ing_oh[r_ing]  = 1'b1;
        dst_oh         = '0;
        dst_oh[r_dst_port] = 1'b1;
        for (int p = 0; p < NUM_PORTS; p++) begin
            untag_match[p] = r_untag[p][VID_W] && (r_untag[p][VID_W-1:0] == r_v);
            qual[p]        = untag_match[p] || r_members[p];
        end
        // A destination equal to the source is known unless learning was refused.
        dst_self = (r_dst == r_src) && (r_src_hit || !tbl_full);
        if (dst_self) begin
            pend_init = '0;
        end else if (r_dst_hit) begin
            pend_init = dst_oh & qual & ~ing_oh;
        end else begin
            pend_init = qual & ~ing_oh;
        end
    end

    logic [NUM_PORTS-1:0] r_pend;
    logic [PORT_W-1:0]    sel;
    logic [NUM_PORTS-1:0] sel_oh;
    logic [1:0]           sel_act;

    always_comb begin
        sel = '0;
        for (int p = NUM_PORTS - 1; p >= 0; p--) begin
            if (r_pend[p]) sel = PORT_W'(p);
        end
        sel_oh      = '0;
        sel_oh[sel] = 1'b1;
        if (untag_match[sel]) begin
            sel_act = r_tagged ? ACT_STRIP : ACT_FWD;
        end else begin
            sel_act = r_tagged ? ACT_FWD : ACT_INSERT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (i_cmd.learn) begin
            r_pend <= pend_init;
        end else if (i_cmd.emit) begin
            r_pend <= r_pend & ~sel_oh;
        end
    end

    // Output word register.
    logic                r_out_vld;
    logic [PORT_W-1:0]   r_out_port;
    logic [1:0]          r_out_act;
    logic [VID_W-1:0]    r_out_vid;
    logic                r_out_last;
    logic                out_free;

    assign out_free = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_port <= sel;
            r_out_act  <= sel_act;
            r_out_vid  <= (sel_act == ACT_INSERT) ? r_v : '0;
            r_out_last <= ((r_pend & ~sel_oh) == '0);
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_out_vid, r_out_act, r_out_port};
    assign o_m_tlast  = r_out_last;

    always_comb begin
        o_status.cmd       = r_cmd;
        o_status.port_ok   = port_ok;
        o_status.admit     = port_ok && (r_tagged ? r_members[r_ing] : r_untag[r_ing][VID_W]);
        o_status.clr_done  = (r_clr_addr == VID_W'(VLAN_SLOTS - 1));
        o_status.scan_done = (r_ptr >= r_count) && !r_rd_vld;
        o_status.pend_any  = (r_pend != '0);
        o_status.out_free  = out_free;
    end
endmodule
`default_nettype wire

// File: sv/vlan_learning_switch_forwarder.sv
// Block usage:
// Input stream (i_s_axis_*) carries one word per frame header or set-up command;
// tuser holds the command, tdata the header fields. Output stream (o_m_axis_*)
// carries forwarding decisions, one word per egress port in ascending port order,
// tlast marking the final decision of a frame. Rejected frames, frames with no
// egress and set-up commands give no words.
// One item is worked on at a time. The MAC table holds up to 512 learned addresses
// and is scanned one entry per cycle through a single read port, matching source
// and destination in the same pass. After reset the block clears the 4096-entry
// VLAN membership memory, one entry per cycle, and holds tready low until the
// sweep is done.
// Decisions sit in an output register; when the receiver stalls, the next decision
// of the frame waits and no item is accepted until the register is taken. Once the
// last decision of a frame is in the register, the next item can be accepted.
// Depends on vlsf_pkg, vlsf_ctrl and vlsf_dp.
`default_nettype none
module vlan_learning_switch_forwarder
    import vlsf_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata: ingress_port, src_mac, dst_mac, is_tagged, vid, member_mask,
    // untagged_enable, zero fill
    input  wire [IN_DATA_W-1:0]   i_s_axis_tdata,
    // tuser: cmd
    input  wire [1:0]             i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  wire                   i_m_axis_tready,
    // tdata: egress_port, action, tag_vid
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                  o_m_axis_tlast
);
    t_dp_cmd    cmd;
    t_dp_status status;

    vlsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    vlsf_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tlast  (o_m_axis_tlast)
    );
endmodule
`default_nettype wire

// File: sv/vlsf_checker.sv
// Port-level checker of the forwarder, bound to the top level.
// Depends on vlsf_pkg and vlan_learning_switch_forwarder_assert.svh.
`default_nettype none
`include "vlan_learning_switch_forwarder_assert.svh"
module vlsf_checker
    import vlsf_pkg::*;
(
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_s_axis_tvalid,
    input wire                  o_s_axis_tready,
    input wire [IN_DATA_W-1:0]  i_s_axis_tdata,
    input wire [1:0]            i_s_axis_tuser,
    input wire                  o_m_axis_tvalid,
    input wire                  i_m_axis_tready,
    input wire [OUT_DATA_W-1:0] o_m_axis_tdata,
    input wire                  o_m_axis_tlast
);
    `VLSF_ASSERT(out_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid, "output word dropped while stalled")
    `VLSF_ASSERT(one_at_a_time, i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready, "input taken while an item is in work")
    `VLSF_ASSERT_RST(reset_quiet, !i_rst_n |=> !o_s_axis_tready && !o_m_axis_tvalid, "block active right after reset")
    `VLSF_ASSERT(vid_only_insert, o_m_axis_tvalid && o_m_axis_tdata[3:2] != ACT_INSERT |-> o_m_axis_tdata[15:4] == 12'd0 && o_m_axis_tdata[3:2] != 2'd3, "bad action or stray tag VID")
endmodule

bind vlan_learning_switch_forwarder vlsf_checker u_vlsf_checker (.*);
`default_nettype wire
